// ===== src/tlsp_pkg.sv =====
package tlsp_pkg;

    typedef struct packed {
        logic       new_connection;
        logic [7:0] data_byte;
    } tlsp_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  name_kind;
        logic [7:0]  name_byte;
        logic        alpn_separator_after;
        logic [15:0] host_length;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
    } tlsp_out_t;

    typedef enum logic [4:0] {
        PH_HS_HDR, PH_VERSION, PH_RANDOM, PH_SID_LEN, PH_SID, PH_CS_LEN, PH_CS,
        PH_CM_LEN, PH_CM, PH_EXT, PH_EXT_HDR, PH_SNI_LEN, PH_SNI_HEAD, PH_SNI_HOST,
        PH_ALPN_LEN, PH_ALPN_PLEN, PH_ALPN_DATA, PH_SUPVER_LEN
    } tlsp_phase_t;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_DECL = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_ALPN = 2'd2;

    localparam logic [7:0] REC_HANDSHAKE = 8'h16;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0] EXT_ALPN = 8'd16;
    localparam logic [7:0] EXT_SUPVER = 8'd43;
    localparam logic [7:0] RANDOM_LEN = 8'd32;

    typedef enum logic [1:0] {
        C_IDLE, C_BYTE, C_TRANS, C_OUT
    } tlsp_cstate_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic do_byte;
        logic do_trans;
    } tlsp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walking;
    } tlsp_stat_t;

endpackage

// ===== src/tls_client_hello_sni_parser_unit.sv =====
// Channel  | Ports                    | Word
// input    | s_valid/s_ready/s_data   | tlsp_in_t: new_connection, data_byte
// result   | m_valid/m_ready/m_data   | tlsp_out_t: status, name, version
// config   | enable_we/enable_wdata   | enable bit, no handshake
// Steps: each record-header or ignored byte is loaded, given a byte step and offered as a result;
// a handshake byte also takes one field transition for each field transition it triggers.
// Zero-length fields cascade, one transition per cycle.
// One byte in flight; s_ready is high only while no result is pending.
// Reset: synchronous aresetn low clears parse state and disables the block.
// A stalled result holds m_valid and m_data until m_ready.
module tls_client_hello_sni_parser_unit
    import tlsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      enable_we,
    input  logic      enable_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  tlsp_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tlsp_out_t m_data
);

    logic       enable_reg;
    tlsp_cmd_t  cmd;
    tlsp_stat_t stat;

    // config register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) enable_reg <= 1'b0;
        else if (enable_we) enable_reg <= enable_wdata;
    end

    tlsp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    tlsp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .enable(enable_reg), .in_word(s_data),
        .cmd(cmd), .stat(stat), .out_word(m_data)
    );

endmodule

// ===== src/tlsp_datapath.sv =====
module tlsp_datapath
    import tlsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      enable,
    input  tlsp_in_t  in_word,
    input  tlsp_cmd_t cmd,
    output tlsp_stat_t stat,
    output tlsp_out_t out_word
);

    tlsp_phase_t ph_reg, ph_next;
    logic [7:0]  hdr_reg [5];
    logic [7:0]  hdr_next [5];
    logic [2:0]  hcnt_reg, hcnt_next;
    logic        inrec_reg, inrec_next;
    logic [15:0] rec_reg, rec_next;
    logic [23:0] fld_reg, fld_next;
    logic [23:0] hs_reg, hs_next;
    logic [15:0] ext_reg, ext_next;
    logic [7:0]  cap_reg [4];
    logic [7:0]  cap_next [4];
    logic [7:0]  cidx_reg, cidx_next;
    logic [7:0]  vmaj_reg, vmaj_next, vmin_reg, vmin_next;
    logic        hseen_reg, hseen_next, aseen_reg, aseen_next;
    logic [1:0]  st_reg, st_next;
    logic [15:0] hlen_reg, hlen_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic        sep_reg, sep_next;
    logic        walk_reg, walk_next;

    logic [23:0] sz;
    logic [16:0] need;
    logic [7:0]  b;

    always_comb begin
        ph_next = ph_reg; hcnt_next = hcnt_reg; inrec_next = inrec_reg;
        rec_next = rec_reg; fld_next = fld_reg; hs_next = hs_reg; ext_next = ext_reg;
        cidx_next = cidx_reg; vmaj_next = vmaj_reg; vmin_next = vmin_reg;
        hseen_next = hseen_reg; aseen_next = aseen_reg; st_next = st_reg;
        hlen_next = hlen_reg; kind_next = kind_reg; byte_next = byte_reg;
        sep_next = sep_reg; walk_next = 1'b0;
        for (int i = 0; i < 5; i++) hdr_next[i] = hdr_reg[i];
        for (int i = 0; i < 4; i++) cap_next[i] = cap_reg[i];
        sz = '0; need = '0;
        b = byte_reg;
        if (cmd.load) begin
            b = in_word.data_byte;
            byte_next = in_word.data_byte;
            kind_next = KIND_NONE;
            sep_next = 1'b0;
            if (in_word.new_connection) begin
                ph_next = PH_HS_HDR; hcnt_next = '0; inrec_next = 1'b0; rec_next = '0;
                fld_next = 24'd4; hs_next = 24'd4; ext_next = '0; cidx_next = '0;
                vmaj_next = '0; vmin_next = '0; hseen_next = 1'b0; aseen_next = 1'b0;
                st_next = ST_MORE; hlen_next = '0;
                for (int i = 0; i < 5; i++) hdr_next[i] = '0;
                for (int i = 0; i < 4; i++) cap_next[i] = '0;
            end
            if (!in_word.new_connection && st_reg != ST_MORE) begin
                // finished stream holds
            end else if (!enable) begin
                st_next = ST_DECL;
            end else if (!(inrec_reg && !in_word.new_connection)) begin
                hdr_next[hcnt_next] = b;
                if (hcnt_next != 3'd4) begin
                    hcnt_next = hcnt_next + 3'd1;
                end else begin
                    hcnt_next = '0;
                    if (hdr_next[0][7] && hdr_next[2] == 8'd1 &&
                        (hdr_next[3] == 8'd0 || hdr_next[3] == 8'd3)) begin
                        vmaj_next = hdr_next[3]; vmin_next = hdr_next[4];
                        st_next = ST_DONE;
                    end else if (hdr_next[0] != REC_HANDSHAKE || hdr_next[1] != 8'd3) begin
                        st_next = ST_DECL;
                    end else begin
                        rec_next = {hdr_next[3], hdr_next[4]};
                        inrec_next = rec_next != 16'd0;
                    end
                end
            end else begin
                walk_next = 1'b1;
            end
        end else if (cmd.do_byte) begin
            walk_next = 1'b0;
            rec_next = rec_reg - 16'd1;
            if (rec_next == 16'd0) inrec_next = 1'b0;
            if (fld_reg == 24'd0) begin
                st_next = ST_DECL;
            end else begin
                case (ph_reg)
                    PH_SNI_HOST:  kind_next = KIND_HOST;
                    PH_ALPN_DATA: kind_next = KIND_ALPN;
                    PH_VERSION: begin
                        if (cidx_reg[0]) vmin_next = b; else vmaj_next = b;
                    end
                    PH_HS_HDR, PH_SID_LEN, PH_CS_LEN, PH_CM_LEN, PH_EXT_HDR,
                    PH_SNI_LEN, PH_SNI_HEAD, PH_ALPN_LEN, PH_ALPN_PLEN,
                    PH_SUPVER_LEN: begin
                        if (cidx_reg < 8'd4) cap_next[cidx_reg[1:0]] = b;
                    end
                    default: ;
                endcase
                cidx_next = cidx_reg + 8'd1;
                fld_next = fld_reg - 24'd1;
                hs_next = hs_reg - 24'd1;
                if (ph_reg == PH_ALPN_DATA && fld_next == 24'd0 && ext_reg != 16'd0)
                    sep_next = 1'b1;
                walk_next = fld_next == 24'd0;
            end
        end else if (cmd.do_trans) begin
            // one field transition per cycle
            walk_next = 1'b0;
            sz = fld_reg;
            case (ph_reg)
                PH_HS_HDR: begin
                    if (cap_reg[0] != HS_CLIENT_HELLO) st_next = ST_DECL;
                    ph_next = PH_VERSION; sz = 24'd2;
                    hs_next = {cap_reg[1], cap_reg[2], cap_reg[3]};
                end
                PH_VERSION: begin ph_next = PH_RANDOM; sz = {16'd0, RANDOM_LEN}; end
                PH_RANDOM:  begin ph_next = PH_SID_LEN; sz = 24'd1; end
                PH_SID_LEN: begin ph_next = PH_SID; sz = {16'd0, cap_reg[0]}; end
                PH_SID:     begin ph_next = PH_CS_LEN; sz = 24'd2; end
                PH_CS_LEN:  begin ph_next = PH_CS; sz = {8'd0, cap_reg[0], cap_reg[1]}; end
                PH_CS:      begin ph_next = PH_CM_LEN; sz = 24'd1; end
                PH_CM_LEN:  begin ph_next = PH_CM; sz = {16'd0, cap_reg[0]}; end
                PH_CM, PH_EXT: begin
                    if (hs_reg == 24'd0) st_next = ST_DONE;
                    ph_next = (ph_reg == PH_CM) ? PH_EXT : PH_EXT_HDR;
                    sz = (ph_reg == PH_CM) ? 24'd2 : 24'd4;
                end
                PH_EXT_HDR: begin
                    if (cap_reg[0] == 8'd0 && cap_reg[1] == 8'd0 && !hseen_reg) begin
                        ph_next = PH_SNI_LEN; sz = 24'd2;
                    end else if (cap_reg[0] == 8'd0 && cap_reg[1] == EXT_ALPN &&
                                 !aseen_reg) begin
                        ph_next = PH_ALPN_LEN; sz = 24'd2;
                    end else if (cap_reg[0] == 8'd0 && cap_reg[1] == EXT_SUPVER) begin
                        ph_next = PH_SUPVER_LEN; sz = 24'd1;
                    end else begin
                        ph_next = PH_EXT; sz = {8'd0, cap_reg[2], cap_reg[3]};
                    end
                end
                PH_SNI_LEN: begin
                    ext_next = {cap_reg[0], cap_reg[1]};
                    ph_next = PH_SNI_HEAD; sz = 24'd3;
                end
                PH_SNI_HEAD: begin
                    sz = {8'd0, cap_reg[1], cap_reg[2]};
                    need = 17'd3 + {1'b0, cap_reg[1], cap_reg[2]};
                    if (cap_reg[0] != 8'd0 || {1'b0, ext_reg} < need) st_next = ST_DECL;
                    ext_next = ext_reg - need[15:0];
                    hseen_next = 1'b1;
                    ph_next = PH_SNI_HOST;
                end
                PH_SNI_HOST: begin
                    hlen_next = {cap_reg[1], cap_reg[2]};
                    ph_next = PH_EXT; sz = {8'd0, ext_reg};
                end
                PH_ALPN_LEN: begin
                    ext_next = {cap_reg[0], cap_reg[1]};
                    aseen_next = 1'b1;
                    ph_next = PH_ALPN_PLEN; sz = 24'd1;
                end
                PH_ALPN_PLEN: begin
                    sz = {16'd0, cap_reg[0]};
                    need = 17'd1 + {9'd0, cap_reg[0]};
                    if (cap_reg[0] == 8'd0 || {1'b0, ext_reg} < need) st_next = ST_DECL;
                    ext_next = ext_reg - need[15:0];
                    ph_next = PH_ALPN_DATA;
                end
                PH_ALPN_DATA: begin
                    if (ext_reg != 16'd0) begin
                        ph_next = PH_ALPN_PLEN; sz = 24'd1;
                    end else begin
                        ph_next = PH_EXT; sz = 24'd0;
                    end
                end
                PH_SUPVER_LEN: begin
                    vmaj_next = 8'd3; vmin_next = 8'd4;
                    ph_next = PH_EXT; sz = {16'd0, cap_reg[0]};
                end
                default: st_next = ST_DECL;
            endcase
            if (st_next == ST_MORE) begin
                fld_next = sz;
                cidx_next = '0;
                if (hs_next < sz) st_next = ST_DECL;
                walk_next = sz == 24'd0 && st_next == ST_MORE;
            end else begin
                // terminal transition leaves the walker as it was
                ph_next = ph_reg; hs_next = hs_reg; ext_next = ext_reg;
                hseen_next = hseen_reg; aseen_next = aseen_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_HS_HDR; hcnt_reg <= '0; inrec_reg <= 1'b0; rec_reg <= '0;
            fld_reg <= 24'd4; hs_reg <= 24'd4; ext_reg <= '0; cidx_reg <= '0;
            vmaj_reg <= '0; vmin_reg <= '0; hseen_reg <= 1'b0; aseen_reg <= 1'b0;
            st_reg <= ST_MORE; hlen_reg <= '0; walk_reg <= 1'b0;
            kind_reg <= KIND_NONE; sep_reg <= 1'b0; byte_reg <= '0;
            for (int i = 0; i < 5; i++) hdr_reg[i] <= '0;
            for (int i = 0; i < 4; i++) cap_reg[i] <= '0;
        end else begin
            ph_reg <= ph_next; hcnt_reg <= hcnt_next; inrec_reg <= inrec_next;
            rec_reg <= rec_next; fld_reg <= fld_next; hs_reg <= hs_next;
            ext_reg <= ext_next; cidx_reg <= cidx_next; vmaj_reg <= vmaj_next;
            vmin_reg <= vmin_next; hseen_reg <= hseen_next; aseen_reg <= aseen_next;
            st_reg <= st_next; hlen_reg <= hlen_next; walk_reg <= walk_next;
            kind_reg <= kind_next; sep_reg <= sep_next; byte_reg <= byte_next;
            for (int i = 0; i < 5; i++) hdr_reg[i] <= hdr_next[i];
            for (int i = 0; i < 4; i++) cap_reg[i] <= cap_next[i];
        end
    end

    assign stat.walking = walk_reg;

    always_comb begin
        out_word.status = st_reg;
        out_word.name_kind = kind_reg;
        out_word.name_byte = (kind_reg != KIND_NONE) ? byte_reg : 8'd0;
        out_word.alpn_separator_after = sep_reg;
        out_word.host_length = hlen_reg;
        out_word.version_major = vmaj_reg;
        out_word.version_minor = vmin_reg;
    end

endmodule

// ===== src/tlsp_ctrl.sv =====
module tlsp_ctrl
    import tlsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  tlsp_stat_t stat,
    output tlsp_cmd_t  cmd
);

    tlsp_cstate_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (s_valid) state_next = C_BYTE;
            C_BYTE:  state_next = stat.walking ? C_TRANS : C_OUT;
            C_TRANS: state_next = stat.walking ? C_TRANS : C_OUT;
            C_OUT:   if (m_ready) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            C_IDLE:  begin s_ready = 1'b1; cmd.load = s_valid; end
            C_BYTE:  cmd.do_byte = stat.walking;
            C_TRANS: cmd.do_trans = stat.walking;
            C_OUT:   m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= C_IDLE;
        else state_reg <= state_next;
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid both high");
    a_load_next: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == C_BYTE) else $error("load not followed by byte step");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");

endmodule

// ===== bench/tlsp_hello_checker.sv =====
`timescale 1ns / 1ps

module tlsp_hello_checker
    import tlsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      enable_we,
    input  logic      enable_wdata,
    input  logic      s_valid,
    input  logic      s_ready,
    input  tlsp_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  tlsp_out_t m_data,
    output int        pending,
    output int        errors
);

    // mirror of the parser state
    logic        en;
    tlsp_phase_t ph;
    logic [7:0]  hdr [5];
    logic [15:0] rec_rem;
    logic [23:0] fld_rem;
    logic [23:0] hs_rem;
    logic [15:0] ext_rem;
    logic [7:0]  cap [4];
    logic [7:0]  ver [2];
    bit          host_seen;
    bit          alpn_seen;
    logic [1:0]  fin;
    int          hdr_cnt;
    bit          in_rec;
    logic [7:0]  cap_idx;
    logic [15:0] host_len;

    tlsp_out_t hello_results_q[$];

    function automatic void clear_stream();
        ph = PH_HS_HDR;
        foreach (hdr[i]) hdr[i] = '0;
        foreach (cap[i]) cap[i] = '0;
        ver[0] = '0;
        ver[1] = '0;
        rec_rem = '0;
        fld_rem = 24'd4;
        hs_rem = 24'd4;
        ext_rem = '0;
        host_seen = 0;
        alpn_seen = 0;
        fin = ST_MORE;
        hdr_cnt = 0;
        in_rec = 0;
        cap_idx = '0;
        host_len = '0;
    endfunction

    // field finished: pick the next field and its size
    function automatic logic [1:0] next_field();
        int          sz;
        tlsp_phase_t nph;
        sz = 0;
        nph = ph;
        case (ph)
            PH_HS_HDR: begin
                if (cap[0] != HS_CLIENT_HELLO) return ST_DECL;
                nph = PH_VERSION;
                sz = 2;
                hs_rem = {cap[1], cap[2], cap[3]};
            end
            PH_VERSION: begin nph = PH_RANDOM; sz = int'(RANDOM_LEN); end
            PH_RANDOM: begin nph = PH_SID_LEN; sz = 1; end
            PH_SID_LEN: begin nph = PH_SID; sz = int'(cap[0]); end
            PH_SID: begin nph = PH_CS_LEN; sz = 2; end
            PH_CS_LEN: begin nph = PH_CS; sz = int'({cap[0], cap[1]}); end
            PH_CS: begin nph = PH_CM_LEN; sz = 1; end
            PH_CM_LEN: begin nph = PH_CM; sz = int'(cap[0]); end
            PH_CM, PH_EXT: begin
                if (hs_rem == 0) return ST_DONE;
                nph = (ph == PH_CM) ? PH_EXT : PH_EXT_HDR;
                sz = (ph == PH_CM) ? 2 : 4;
            end
            PH_EXT_HDR: begin
                if (cap[0] == 0 && cap[1] == 0 && !host_seen) begin
                    nph = PH_SNI_LEN; sz = 2;
                end else if (cap[0] == 0 && cap[1] == EXT_ALPN && !alpn_seen) begin
                    nph = PH_ALPN_LEN; sz = 2;
                end else if (cap[0] == 0 && cap[1] == EXT_SUPVER) begin
                    nph = PH_SUPVER_LEN; sz = 1;
                end else begin
                    nph = PH_EXT; sz = int'({cap[2], cap[3]});
                end
            end
            PH_SNI_LEN: begin
                ext_rem = {cap[0], cap[1]};
                nph = PH_SNI_HEAD;
                sz = 3;
            end
            PH_SNI_HEAD: begin
                if (cap[0] != 0) return ST_DECL;
                sz = int'({cap[1], cap[2]});
                if (int'(ext_rem) < 3 + sz) return ST_DECL;
                ext_rem = ext_rem - 16'(3 + sz);
                host_seen = 1;
                nph = PH_SNI_HOST;
            end
            PH_SNI_HOST: begin
                host_len = {cap[1], cap[2]};
                nph = PH_EXT;
                sz = int'(ext_rem);
            end
            PH_ALPN_LEN: begin
                ext_rem = {cap[0], cap[1]};
                alpn_seen = 1;
                nph = PH_ALPN_PLEN;
                sz = 1;
            end
            PH_ALPN_PLEN: begin
                sz = int'(cap[0]);
                if (sz == 0) return ST_DECL;
                if (int'(ext_rem) < 1 + sz) return ST_DECL;
                ext_rem = ext_rem - 16'(1 + sz);
                nph = PH_ALPN_DATA;
            end
            PH_ALPN_DATA: begin
                if (ext_rem != 0) begin nph = PH_ALPN_PLEN; sz = 1; end
                else begin nph = PH_EXT; sz = 0; end
            end
            PH_SUPVER_LEN: begin
                ver[0] = 8'd3;
                ver[1] = 8'd4;
                nph = PH_EXT;
                sz = int'(cap[0]);
            end
            default: return ST_DECL;
        endcase
        ph = nph;
        fld_rem = sz[23:0];
        cap_idx = '0;
        if (hs_rem < fld_rem) return ST_DECL;
        return ST_MORE;
    endfunction

    function automatic logic [1:0] handshake_byte(input logic [7:0] b,
                                                  output logic [1:0] kind,
                                                  output logic sep);
        tlsp_phase_t cur;
        logic [1:0]  st;
        cur = ph;
        st = ST_MORE;
        kind = KIND_NONE;
        sep = 0;
        if (fld_rem == 0) return ST_DECL;
        if (cur == PH_SNI_HOST) kind = KIND_HOST;
        else if (cur == PH_ALPN_DATA) kind = KIND_ALPN;
        else if (cur == PH_VERSION) ver[cap_idx[0]] = b;
        else if (cur inside {PH_HS_HDR, PH_SID_LEN, PH_CS_LEN, PH_CM_LEN, PH_EXT_HDR,
                             PH_SNI_LEN, PH_SNI_HEAD, PH_ALPN_LEN, PH_ALPN_PLEN,
                             PH_SUPVER_LEN} && cap_idx < 4)
            cap[cap_idx[1:0]] = b;
        cap_idx = cap_idx + 8'd1;
        fld_rem = fld_rem - 24'd1;
        hs_rem = hs_rem - 24'd1;
        if (cur == PH_ALPN_DATA && fld_rem == 0 && ext_rem != 0) sep = 1;
        while (st == ST_MORE && fld_rem == 0) st = next_field();
        return st;
    endfunction

    function automatic logic [1:0] record_header_byte(input logic [7:0] b);
        if (hdr_cnt < 5) hdr[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt < 5) return ST_MORE;
        hdr_cnt = 0;
        // SSLv2-style hello is accepted as is
        if (hdr[0][7] && hdr[2] == 8'd1 && (hdr[3] == 0 || hdr[3] == 8'd3)) begin
            ver[0] = hdr[3];
            ver[1] = hdr[4];
            return ST_DONE;
        end
        if (hdr[0] != REC_HANDSHAKE) return ST_DECL;
        if (hdr[1] != 8'd3) return ST_DECL;
        rec_rem = {hdr[3], hdr[4]};
        in_rec = rec_rem != 0;
        return ST_MORE;
    endfunction

    function automatic tlsp_out_t parse_byte(input tlsp_in_t w);
        tlsp_out_t  r;
        logic [1:0] kind;
        logic       sep;
        kind = KIND_NONE;
        sep = 0;
        if (w.new_connection) clear_stream();
        if (fin == ST_MORE) begin
            if (!en) fin = ST_DECL;
            else if (!in_rec) fin = record_header_byte(w.data_byte);
            else begin
                rec_rem = rec_rem - 16'd1;
                fin = handshake_byte(w.data_byte, kind, sep);
                if (rec_rem == 0) in_rec = 0;
            end
        end
        r.status = fin;
        r.name_kind = kind;
        r.name_byte = (kind != KIND_NONE) ? w.data_byte : 8'd0;
        r.alpn_separator_after = sep;
        r.host_length = host_len;
        r.version_major = ver[0];
        r.version_minor = ver[1];
        return r;
    endfunction

    always @(posedge aclk) begin
        tlsp_out_t want;
        if (!aresetn) begin
            en = 0;
            clear_stream();
            hello_results_q.delete();
        end else begin
            if (enable_we) en = enable_wdata;
            if (m_valid && m_ready) begin
                if (hello_results_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, m_data);
                end else begin
                    want = hello_results_q.pop_front();
                    if (m_data !== want) begin
                        errors++;
                        $display({"%0t: result mismatch expected st=%0d kind=%0d byte=%h",
                                  " sep=%0d hlen=%0d ver=%0d.%0d actual st=%0d kind=%0d",
                                  " byte=%h sep=%0d hlen=%0d ver=%0d.%0d"}, $time,
                                 want.status, want.name_kind, want.name_byte,
                                 want.alpn_separator_after, want.host_length,
                                 want.version_major, want.version_minor,
                                 m_data.status, m_data.name_kind, m_data.name_byte,
                                 m_data.alpn_separator_after, m_data.host_length,
                                 m_data.version_major, m_data.version_minor);
                    end
                end
            end
            if (s_valid && s_ready) hello_results_q.push_back(parse_byte(s_data));
        end
        pending = hello_results_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tlsp_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      enable_we;
    logic      enable_wdata;
    logic      s_valid;
    logic      s_ready;
    tlsp_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    tlsp_out_t m_data;
    int        pending;
    int        errors;

    bit         quiet;      // phase with no idling on either side
    int         words_sent;
    logic [7:0] body_q[$];  // handshake message being built
    logic [7:0] ext_q[$];   // extension block being built
    logic [7:0] wire_q[$];  // record-framed bytes for one connection

    tls_client_hello_sni_parser_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .enable_we   (enable_we),
        .enable_wdata(enable_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    tlsp_hello_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .enable_we   (enable_we),
        .enable_wdata(enable_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .pending     (pending),
        .errors      (errors)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall per word
    initial begin
        int stall;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one word; valid stays up when the next word follows at once
    task automatic send_word(input bit nc, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= '{new_connection: nc, data_byte: b};
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_wire();
        foreach (wire_q[i]) send_word(i == 0, wire_q[i]);
        wire_q.delete();
    endtask

    // drain all results, then let the block settle
    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_enable(input logic v);
        enable_we <= 1;
        enable_wdata <= v;
        @(posedge aclk);
        enable_we <= 0;
    endtask

    task automatic push16(ref logic [7:0] q[$], input int v);
        q.push_back(v[15:8]);
        q.push_back(v[7:0]);
    endtask

    task automatic push_rand(ref logic [7:0] q[$], input int n);
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
    endtask

    // extensions in random order, repeats allowed
    task automatic build_extensions();
        int kind, n, len, plen;
        logic [7:0] lst[$];
        ext_q.delete();
        repeat ($urandom_range(0, 4)) begin
            kind = $urandom_range(0, 3);
            lst.delete();
            case (kind)
                0: begin
                    // server_name: list len, name type, host len, host
                    n = $urandom_range(0, 12);
                    lst.push_back(8'(($urandom_range(0, 9) == 0) ?
                                     $urandom_range(1, 255) : 0));
                    push16(lst, n);
                    repeat (n) lst.push_back(8'($urandom_range(0, 255)));
                    push16(ext_q, 0);
                    push16(ext_q, lst.size() + 2);
                    push16(ext_q, lst.size());
                end
                1: begin
                    repeat ($urandom_range(1, 3)) begin
                        plen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                        lst.push_back(8'(plen));
                        push_rand(lst, plen);
                    end
                    push16(ext_q, int'(EXT_ALPN));
                    push16(ext_q, lst.size() + 2);
                    push16(ext_q, lst.size());
                end
                2: begin
                    n = 2 * $urandom_range(0, 3);
                    lst.push_back(8'(n));
                    push_rand(lst, n);
                    push16(ext_q, int'(EXT_SUPVER));
                    push16(ext_q, lst.size());
                end
                default: begin
                    len = $urandom_range(0, 6);
                    push16(ext_q, int'(($urandom_range(0, 1) ? 16'hff00 : 16'h0005) |
                                       16'($urandom_range(0, 255))));
                    push16(ext_q, len);
                    push_rand(lst, len);
                end
            endcase
            foreach (lst[i]) ext_q.push_back(lst[i]);
        end
    endtask

    // a ClientHello, framed into records, sometimes damaged
    task automatic build_hello();
        int n, pos, chunk, total;
        logic [7:0] hs[$];
        body_q.delete();
        body_q.push_back(8'd3);
        body_q.push_back(8'($urandom_range(0, 4)));
        push_rand(body_q, int'(RANDOM_LEN));
        n = $urandom_range(0, 8) == 0 ? 32 : $urandom_range(0, 4);
        body_q.push_back(8'(n));
        push_rand(body_q, n);
        n = 2 * $urandom_range(1, 3);
        push16(body_q, n);
        push_rand(body_q, n);
        n = $urandom_range(1, 2);
        body_q.push_back(8'(n));
        push_rand(body_q, n);
        build_extensions();
        if (ext_q.size() != 0 || $urandom_range(0, 3) == 0) begin
            push16(body_q, ext_q.size());
            foreach (ext_q[i]) body_q.push_back(ext_q[i]);
        end
        hs.push_back(HS_CLIENT_HELLO);
        hs.push_back(8'd0);
        push16(hs, body_q.size());
        foreach (body_q[i]) hs.push_back(body_q[i]);
        if ($urandom_range(0, 5) == 0)
            hs[$urandom_range(0, hs.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            hs = hs[0:$urandom_range(0, hs.size() - 1)];
        total = hs.size();
        pos = 0;
        while (pos < total) begin
            if ($urandom_range(0, 9) == 0) begin
                wire_q.push_back(REC_HANDSHAKE);
                wire_q.push_back(8'd3);
                wire_q.push_back(8'd1);
                push16(wire_q, 0);
            end
            chunk = $urandom_range(0, 2) == 0 ? $urandom_range(1, total - pos) : total - pos;
            wire_q.push_back(REC_HANDSHAKE);
            wire_q.push_back(8'd3);
            wire_q.push_back(8'($urandom_range(0, 3)));
            push16(wire_q, chunk);
            repeat (chunk) begin
                wire_q.push_back(hs[pos]);
                pos++;
            end
        end
        // trailing bytes after the hello are ignored
        push_rand(wire_q, $urandom_range(0, 2));
    endtask

    initial begin
        int streams;
        aresetn = 0;
        enable_we = 0;
        enable_wdata = 0;
        s_valid = 0;
        s_data = '0;
        quiet = 0;
        words_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: disabled after reset
        send_word(1, REC_HANDSHAKE);
        wait_idle();
        write_enable(1);
        // SSLv2-style hello, then a byte after the verdict
        wire_q = '{8'h80, 8'h00, 8'h01, 8'h03, 8'h01, 8'hff};
        send_wire();
        // wrong record type, wrong major version
        wire_q = '{8'h17, 8'h03, 8'h01, 8'h00, 8'h05};
        send_wire();
        wire_q = '{8'h16, 8'h02, 8'h01, 8'hff, 8'hff};
        send_wire();
        // empty record, then a handshake that is not a ClientHello
        wire_q = '{8'h16, 8'h03, 8'h01, 8'h00, 8'h00,
                   8'h16, 8'h03, 8'h01, 8'h00, 8'h04, 8'h02};
        send_wire();
        wait_idle();

        // random: mostly well-formed hellos, some noise
        streams = 0;
        while (words_sent < 950) begin
            if ($urandom_range(0, 7) == 0) begin
                wire_q.push_back($urandom_range(0, 1) ? REC_HANDSHAKE :
                                 8'($urandom_range(0, 255)));
                push_rand(wire_q, $urandom_range(1, 12));
            end else begin
                build_hello();
            end
            send_wire();
            streams++;
            if (streams % 4 == 0) begin
                wait_idle();
                quiet = $urandom_range(0, 4) == 0;
                write_enable($urandom_range(0, 6) != 0);
            end
        end
        wait_idle();
        write_enable(0);
        send_word(1, 8'h00);
        wait_idle();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/tlsp_pkg.sv
src/tlsp_datapath.sv
src/tlsp_ctrl.sv
src/tls_client_hello_sni_parser_unit.sv
bench/tlsp_hello_checker.sv
bench/tb.sv
